FILE: sv/kway_merge_min_heap_unit_macros.svh
// Assertion helpers for the heap RTL.
`ifndef KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH
`define KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KWMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwmh same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KWMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwmh next-cycle check failed");

`endif

FILE: sv/kwmh_pkg.sv
package kwmh_pkg;

  localparam int unsigned SRC_W = 4;
  localparam int unsigned OUT_KEY_W = 32;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic                        opcode;
    logic signed [OUT_KEY_W-1:0] key_value;
    logic [SRC_W-1:0]            source_list;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_KEY_W-1:0] min_value;
    logic [SRC_W-1:0]            min_list;
    logic [STATUS_W-1:0]         status;
    logic [OCC_W-1:0]            occupancy;
  } out_item_t;

endpackage

FILE: sv/kway_merge_min_heap_unit.sv
// Sequence: a rejected insert, an empty extract or a first insert goes straight to the
//   response state; any other insert climbs, reading and comparing the parent per level;
//   an extract reads the root, then the last entry, and unless the heap is now empty sifts
//   it down, reading left then right child per level. The result then waits in S_RESP.
// One item at a time: the next is taken once the result is loaded; out_ready stalls delay that.
// Reset (rst_n low, synchronous) empties the heap; entries are not cleared.
`include "kway_merge_min_heap_unit_macros.svh"

module kway_merge_min_heap_unit #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kwmh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kwmh_pkg::out_item_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;  // wide enough for 2*idx+2

  // One heap entry: key plus the list it came from.
  typedef struct packed {
    logic signed [KEY_WIDTH-1:0]  key;
    logic [kwmh_pkg::SRC_W-1:0]   src;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_HOLD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_RESP
  } state_t;

  // Entry memory: one write and one registered read per cycle.
  entry_t mem [CAPACITY];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       at_r, at_nxt;        // current hole position
  entry_t              hold_r, hold_nxt;    // entry being sifted
  entry_t              best_r, best_nxt;    // smaller of hold and left child
  logic                best_left_r, best_left_nxt;
  logic                right_ok_r, right_ok_nxt;
  kwmh_pkg::out_item_t pend_r, pend_nxt;    // result waiting for the output register
  kwmh_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Shared key comparator; operands are steered by state.
  logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                        cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic [XW-1:0] at_x, left_x, right_x, cnt_x;
  logic [AW-1:0] parent;
  entry_t        in_entry;

  assign at_x    = XW'(at_r);
  assign left_x  = (at_x << 1) + XW'(1);
  assign right_x = (at_x << 1) + XW'(2);
  assign cnt_x   = XW'(cnt_r);
  assign parent  = (at_r - AW'(1)) >> 1;

  assign in_entry.key = KEY_WIDTH'(in_data.key_value);
  assign in_entry.src = in_data.source_list;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    at_nxt        = at_r;
    hold_nxt      = hold_r;
    best_nxt      = best_r;
    best_left_nxt = best_left_r;
    right_ok_nxt  = right_ok_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = at_r;
    wr_data       = hold_r;
    cmp_a         = hold_r.key;
    cmp_b         = rd_q.key;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pend_nxt = '0;
          if (in_data.opcode == kwmh_pkg::OP_INSERT) begin
            if (cnt_r == CW'(CAPACITY)) begin
              // Reject: heap unchanged.
              pend_nxt.status    = kwmh_pkg::ST_FULL;
              pend_nxt.occupancy = kwmh_pkg::OCC_W'(cnt_r);
              state_nxt          = S_RESP;
            end else begin
              pend_nxt.status    = kwmh_pkg::ST_INSERTED;
              pend_nxt.occupancy = kwmh_pkg::OCC_W'(cnt_r + CW'(1));
              cnt_nxt            = cnt_r + CW'(1);
              hold_nxt           = in_entry;
              at_nxt             = cnt_r[AW-1:0];
              if (cnt_r == '0) begin
                // First entry lands at the root directly.
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_entry;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              pend_nxt.status    = kwmh_pkg::ST_EMPTY;
              pend_nxt.occupancy = '0;
              state_nxt          = S_RESP;
            end else begin
              state_nxt = S_EX_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (at_r == '0) begin
          // Hold reached the root: drop it there.
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_addr   = parent;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        // Hold climbs only while strictly smaller than its parent.
        cmp_a = hold_r.key;
        cmp_b = rd_q.key;
        if (cmp_lt) begin
          // Move the parent down into the hole and climb.
          wr_en     = 1'b1;
          wr_data   = rd_q;
          at_nxt    = parent;
          state_nxt = S_UP_RD;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_EX_ROOT: begin
        rd_addr   = '0;
        state_nxt = S_EX_LAST;
      end

      S_EX_LAST: begin
        pend_nxt.min_value = kwmh_pkg::OUT_KEY_W'(rd_q.key);
        pend_nxt.min_list  = rd_q.src;
        pend_nxt.status    = kwmh_pkg::ST_EXTRACTED;
        pend_nxt.occupancy = kwmh_pkg::OCC_W'(cnt_r - CW'(1));
        rd_addr            = AW'(cnt_r - CW'(1));
        cnt_nxt            = cnt_r - CW'(1);
        state_nxt          = S_EX_HOLD;
      end

      S_EX_HOLD: begin
        hold_nxt = rd_q;
        at_nxt   = '0;
        if (cnt_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_DN_RDL;
        end
      end

      S_DN_RDL: begin
        // Stop once the hole has no left child.
        if (left_x >= cnt_x) begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_addr   = left_x[AW-1:0];
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        cmp_a         = rd_q.key;
        cmp_b         = hold_r.key;
        best_left_nxt = cmp_lt;
        best_nxt      = cmp_lt ? rd_q : hold_r;
        right_ok_nxt  = (right_x < cnt_x);
        rd_addr       = right_x[AW-1:0];
        state_nxt     = S_DN_CMP;
      end

      S_DN_CMP: begin
        // Right child wins only when strictly smaller than the better of hold and left; ties keep that one.
        cmp_a = rd_q.key;
        cmp_b = best_r.key;
        if (right_ok_r && cmp_lt) begin
          wr_en     = 1'b1;
          wr_data   = rd_q;
          at_nxt    = right_x[AW-1:0];
          state_nxt = S_DN_RDL;
        end else if (best_left_r) begin
          wr_en     = 1'b1;
          wr_data   = best_r;
          at_nxt    = left_x[AW-1:0];
          state_nxt = S_DN_RDL;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    at_r        <= at_nxt;
    hold_r      <= hold_nxt;
    best_r      <= best_nxt;
    best_left_r <= best_left_nxt;
    right_ok_r  <= right_ok_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  `KWMH_ASSERT_NOW(a_full_occ, out_valid_r && out_r.status == kwmh_pkg::ST_FULL, out_r.occupancy == kwmh_pkg::OCC_W'(CAPACITY))
  `KWMH_ASSERT_NOW(a_empty_zero, out_valid_r && out_r.status == kwmh_pkg::ST_EMPTY, out_r.occupancy == '0 && out_r.min_value == '0)
  `KWMH_ASSERT_NEXT(a_insert_grows, in_valid && in_ready && in_data.opcode == kwmh_pkg::OP_INSERT && cnt_r != CW'(CAPACITY), cnt_r == $past(cnt_r) + CW'(1))
  `KWMH_ASSERT_NOW(a_hole_in_range, state_r == S_UP_RD || state_r == S_UP_CMP || state_r == S_DN_RDL, XW'(at_r) < cnt_x)

endmodule

FILE: sim/kway_merge_min_heap_unit_checker.sv
module kway_merge_min_heap_unit_checker #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  kwmh_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  kwmh_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int unsigned NARROW = (KEY_WIDTH >= kwmh_pkg::OUT_KEY_W) ? 0
                                   : kwmh_pkg::OUT_KEY_W - KEY_WIDTH;

  logic signed [kwmh_pkg::OUT_KEY_W-1:0] heap_key [CAPACITY];
  logic [kwmh_pkg::SRC_W-1:0]            heap_src [CAPACITY];
  int unsigned                           held;
  kwmh_pkg::out_item_t                   expected_results [$];

  // Keep only the stored key bits, sign-extended back to the port width.
  function automatic logic signed [kwmh_pkg::OUT_KEY_W-1:0] narrow_key(
    logic signed [kwmh_pkg::OUT_KEY_W-1:0] k);
    logic signed [kwmh_pkg::OUT_KEY_W-1:0] shifted;
    shifted = k <<< NARROW;
    return shifted >>> NARROW;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [kwmh_pkg::OUT_KEY_W-1:0] k;
    logic [kwmh_pkg::SRC_W-1:0]            s;
    k = heap_key[a];
    s = heap_src[a];
    heap_key[a] = heap_key[b];
    heap_src[a] = heap_src[b];
    heap_key[b] = k;
    heap_src[b] = s;
  endfunction

  // Apply one item to the shadow heap and return the result it must produce.
  function automatic kwmh_pkg::out_item_t predict_result(kwmh_pkg::in_item_t item);
    kwmh_pkg::out_item_t res;
    int unsigned         at;
    int unsigned         up;
    int unsigned         best;
    res = '0;
    if (kwmh_pkg::opcode_t'(item.opcode) == kwmh_pkg::OP_INSERT) begin
      if (held >= CAPACITY) begin
        res.status = kwmh_pkg::ST_FULL;
      end else begin
        at = held;
        heap_key[at] = narrow_key(item.key_value);
        heap_src[at] = item.source_list;
        held++;
        while (at > 0) begin
          up = (at - 1) / 2;
          if (!(heap_key[at] < heap_key[up])) break;
          swap_entries(at, up);
          at = up;
        end
        res.status = kwmh_pkg::ST_INSERTED;
      end
    end else if (held == 0) begin
      res.status = kwmh_pkg::ST_EMPTY;
    end else begin
      res.min_value = heap_key[0];
      res.min_list  = heap_src[0];
      held--;
      heap_key[0] = heap_key[held];
      heap_src[0] = heap_src[held];
      at = 0;
      forever begin
        best = at;
        if (2 * at + 1 < held && heap_key[2 * at + 1] < heap_key[best]) best = 2 * at + 1;
        if (2 * at + 2 < held && heap_key[2 * at + 2] < heap_key[best]) best = 2 * at + 2;
        if (best == at) break;
        swap_entries(at, best);
        at = best;
      end
      res.status = kwmh_pkg::ST_EXTRACTED;
    end
    res.occupancy = kwmh_pkg::OCC_W'(held);
    return res;
  endfunction

  function automatic int check_field(string name, logic [kwmh_pkg::OUT_KEY_W-1:0] want,
                                     logic [kwmh_pkg::OUT_KEY_W-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    kwmh_pkg::out_item_t want;
    int                  bad;
    if (!rst_n) begin
      held = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // Compare first: a result never belongs to an item taken at the same edge.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %0h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          bad  = check_field("min_value", want.min_value, out_data.min_value);
          bad += check_field("min_list", want.min_list, out_data.min_list);
          bad += check_field("status", want.status, out_data.status);
          bad += check_field("occupancy", want.occupancy, out_data.occupancy);
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_result(in_data));
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: sim/kway_merge_min_heap_unit_tb.sv
module kway_merge_min_heap_unit_tb;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int          RAND_ITEMS = 2000;
  localparam logic signed [kwmh_pkg::OUT_KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [kwmh_pkg::OUT_KEY_W-1:0] KEY_MIN = 32'sh80000000;

  // Receiver behaviors, switched after a random stretch.
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_BEAT   = 3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  kwmh_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  kwmh_pkg::out_item_t out_data;
  int                  fail_count;
  int                  pending;

  // Stimulus-side bookkeeping: how full the heap should be and where each list stands.
  int                                    occ;
  int                                    sent;
  int                                    burst_left;
  logic signed [kwmh_pkg::OUT_KEY_W-1:0] list_tail [CAPACITY];

  kway_merge_min_heap_unit #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  kway_merge_min_heap_unit_checker #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: several times the slowest legal run (every item waiting out a full
  // sift, the longest sender gap and a sparse receiver).
  initial begin
    #2000000;
    $display("** kway_merge_min_heap_unit: FAILED **");
    $finish;
  end

  // Receiver: hold ready open, flip a coin, stall most cycles, or beat on a fixed
  // rhythm, each for a random stretch, so stalls land on every phase of a sift.
  initial begin
    int mode;
    int stretch;
    int beat;
    out_ready <= 1'b0;
    mode    = RX_OPEN;
    stretch = 0;
    beat    = 0;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        mode    = $urandom_range(RX_BEAT, RX_OPEN);
        stretch = $urandom_range(160, 16);
      end else begin
        stretch--;
      end
      beat++;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
        RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
        default:   out_ready <= (beat % 5) != 0;
      endcase
    end
  end

  // Pick a key: half the time full range, often a narrow band so equal keys meet,
  // and now and then the signed extremes or their neighbors.
  function automatic logic signed [kwmh_pkg::OUT_KEY_W-1:0] pick_key();
    case ($urandom_range(9, 0))
      5, 6:    return $signed(kwmh_pkg::OUT_KEY_W'($urandom_range(8, 0))) - 4;
      7: begin
        case ($urandom_range(3, 0))
          0:       return KEY_MAX;
          1:       return KEY_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      8:       return KEY_MAX - $urandom_range(3, 0);
      9:       return KEY_MIN + $urandom_range(3, 0);
      default: return $urandom();
    endcase
  endfunction

  // Offer one item and hold it until taken. Valid stays high across back-to-back
  // items inside a burst; drop it only when a gap starts.
  task automatic send_item(kwmh_pkg::opcode_t op,
                           logic signed [kwmh_pkg::OUT_KEY_W-1:0] key,
                           logic [kwmh_pkg::SRC_W-1:0] src);
    kwmh_pkg::in_item_t item;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                               : $urandom_range(24, 1);
    end
    item.opcode      = op;
    item.key_value   = key;
    item.source_list = src;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
    if (op == kwmh_pkg::OP_INSERT && occ < CAPACITY) occ++;
    if (op == kwmh_pkg::OP_EXTRACT && occ > 0) occ--;
  endtask

  // Extract carries don't-care key and list fields; randomize them anyway.
  task automatic send_extract();
    send_item(kwmh_pkg::OP_EXTRACT, $urandom(), kwmh_pkg::SRC_W'($urandom_range(15, 0)));
  endtask

  // Well-formed merge: load the heads of k lists, then extract and refill from a
  // list with a key no smaller than its last one, then drain, sometimes past empty.
  task automatic run_merge();
    int                          lists;
    int                          rounds;
    int                          l;
    longint                      next_key;
    lists  = $urandom_range(CAPACITY, 2);
    rounds = $urandom_range(4 * lists, lists);
    for (int i = 0; i < lists; i++) begin
      list_tail[i] = pick_key();
      send_item(kwmh_pkg::OP_INSERT, list_tail[i], kwmh_pkg::SRC_W'(i));
    end
    for (int r = 0; r < rounds; r++) begin
      send_extract();
      l = $urandom_range(lists - 1, 0);
      next_key = longint'(list_tail[l]) + $urandom_range(3, 0);
      // Skip the refill when the list is exhausted or its next key would wrap.
      if ($urandom_range(99, 0) < 85 && next_key <= longint'(KEY_MAX)) begin
        list_tail[l] = kwmh_pkg::OUT_KEY_W'(next_key);
        send_item(kwmh_pkg::OP_INSERT, list_tail[l], kwmh_pkg::SRC_W'(l));
      end
    end
    while (occ > 0) send_extract();
    if ($urandom_range(1, 0) == 1) send_extract();
  endtask

  // Fill past full, then drain past empty.
  task automatic run_fill_drain();
    while (occ < CAPACITY) begin
      send_item(kwmh_pkg::OP_INSERT, pick_key(), kwmh_pkg::SRC_W'($urandom_range(15, 0)));
    end
    repeat ($urandom_range(3, 1)) begin
      send_item(kwmh_pkg::OP_INSERT, pick_key(), kwmh_pkg::SRC_W'($urandom_range(15, 0)));
    end
    while (occ > 0) send_extract();
    repeat ($urandom_range(2, 1)) send_extract();
  endtask

  // Noise: random mix of inserts and extracts with a random bias.
  task automatic run_noise();
    int bias;
    bias = $urandom_range(80, 20);
    repeat ($urandom_range(40, 5)) begin
      if ($urandom_range(99, 0) < bias) begin
        send_item(kwmh_pkg::OP_INSERT, pick_key(), kwmh_pkg::SRC_W'($urandom_range(15, 0)));
      end else begin
        send_extract();
      end
    end
  endtask

  initial begin
    logic signed [kwmh_pkg::OUT_KEY_W-1:0] fill_keys [16] = '{
      KEY_MAX, KEY_MIN, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd5, KEY_MIN + 1,
      KEY_MAX - 1, 32'sd7, -32'sd3, 32'sd5, KEY_MIN, KEY_MAX, 32'sd1, -32'sd1
    };
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    occ        = 0;
    sent       = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extract from empty, fill with extremes and equal keys from
    // different lists, insert into a full heap, then pull the smallest few.
    send_extract();
    for (int i = 0; i < 16; i++) begin
      send_item(kwmh_pkg::OP_INSERT, fill_keys[i], kwmh_pkg::SRC_W'(15 - i));
    end
    send_item(kwmh_pkg::OP_INSERT, 32'sd42, 4'hf);
    repeat (7) send_extract();

    // Random: mostly merges, some fill/drain passes and some noise.
    while (sent < RAND_ITEMS + 25) begin
      case ($urandom_range(9, 0))
        0, 1:    run_fill_drain();
        2, 3:    run_noise();
        default: run_merge();
      endcase
    end
    in_valid <= 1'b0;

    // Let the checker count the last item taken, then drain outstanding results
    // and let the block settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** kway_merge_min_heap_unit: PASSED **");
    end else begin
      $display("** kway_merge_min_heap_unit: FAILED **");
    end
    $finish;
  end

endmodule
